FILE: hw/rtl/odtp_pkg.sv
package odtp_pkg;

    localparam int SECTOR_W  = 24;
    localparam int LATENCY_W = 16;
    localparam int REPEAT_W  = 7;
    localparam int STEP_W    = 6;
    localparam int REQ_W     = 3;
    localparam int MODE_W    = 3;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [SECTOR_W-1:0] OPEN_END = 24'hFFFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_INACTIVE = 3'd0,
        MODE_STOPPED  = 3'd1,
        MODE_SEEKING  = 3'd2,
        MODE_PLAYING  = 3'd3,
        MODE_PAUSED   = 3'd4,
        MODE_READING  = 3'd5
    } mode_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEEK_PLAY  = 3'd0,
        REQ_SEEK_PAUSE = 3'd1,
        REQ_SEEK_READ  = 3'd2,
        REQ_TICK       = 3'd3,
        REQ_PLAY       = 3'd4,
        REQ_PAUSE      = 3'd5,
        REQ_STOP       = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        PB_NORMAL     = 2'd0,
        PB_FRAME_SKIP = 2'd1,
        PB_FRAME_STEP = 2'd2,
        PB_FAST_FWD   = 2'd3
    } pb_mode_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PLAYBACK_MODE   = 3'd0;
    localparam logic [2:0] REG_PLAYBACK_SPEED  = 3'd1;
    localparam logic [2:0] REG_REVERSE         = 3'd2;
    localparam logic [2:0] REG_STOP_ENABLE     = 3'd3;
    localparam logic [2:0] REG_STOP_SECTOR     = 3'd4;
    localparam logic [2:0] REG_END_SECTOR      = 3'd5;
    localparam logic [2:0] REG_DISC_END_SECTOR = 3'd6;
    localparam logic [2:0] REG_LASER_MODEL     = 3'd7;

    typedef struct packed {
        logic [STEP_W-1:0]   step;         // two's complement sector step
        logic [REPEAT_W-1:0] repeat_next;
    } trick_t;

    // frame step: ticks a frame is held before moving on
    function automatic logic [REPEAT_W-1:0] step_repeats(input logic [2:0] spd);
        logic [REPEAT_W-1:0] r;
        case (spd)
            3'd2:    r = 7'd2;
            3'd3:    r = 7'd4;
            3'd4:    r = 7'd8;
            3'd5:    r = 7'd16;
            3'd6:    r = 7'd30;
            3'd7:    r = 7'd90;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // fast forward sector step per speed code
    function automatic logic [4:0] ff_step(input logic [2:0] spd);
        logic [4:0] s;
        case (spd)
            3'd1:    s = 5'd2;
            3'd2:    s = 5'd3;
            3'd3:    s = 5'd8;
            3'd4:    s = 5'd14;
            3'd5:    s = 5'd20;
            default: s = 5'd1;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/odtp_if.sv
interface odtp_in_if;
    logic                                valid;
    logic                                ready;
    logic [odtp_pkg::REQ_W-1:0]          req_type;
    logic [odtp_pkg::SECTOR_W-1:0]       target_sector;
    logic [odtp_pkg::LATENCY_W-1:0]      seek_latency;

    modport source (output valid, output req_type, output target_sector,
                    output seek_latency, input ready);
    modport sink   (input valid, input req_type, input target_sector,
                    input seek_latency, output ready);
endinterface

interface odtp_out_if;
    logic                                valid;
    logic                                ready;
    logic                                sector_valid;
    logic [odtp_pkg::SECTOR_W-1:0]       read_sector;
    logic [odtp_pkg::MODE_W-1:0]         mode_now;
    logic                                stop_point_hit;
    logic                                ended;

    modport source (output valid, output sector_valid, output read_sector,
                    output mode_now, output stop_point_hit, output ended,
                    input ready);
    modport sink   (input valid, input sector_valid, input read_sector,
                    input mode_now, input stop_point_hit, input ended,
                    output ready);
endinterface

FILE: hw/rtl/odtp_trick.sv
module odtp_trick (
    input  logic [1:0]                      playback_mode,
    input  logic [2:0]                      playback_speed,
    input  logic                            reverse,
    input  logic [odtp_pkg::REPEAT_W-1:0]   repeat_count,
    output odtp_pkg::trick_t                trick
);

    logic [4:0]                    mag;
    logic                          apply_dir;
    logic [odtp_pkg::REPEAT_W-1:0] rc_inc;
    logic [odtp_pkg::REPEAT_W-1:0] rc_next;

    assign rc_inc = repeat_count + 7'd1;

    always_comb
    begin
        mag       = 5'd1;
        apply_dir = 1'b0;
        rc_next   = '0;
        case (odtp_pkg::pb_mode_t'(playback_mode))
            odtp_pkg::PB_FRAME_STEP:
            begin
                apply_dir = 1'b1;
                if (playback_speed == 3'd0)
                begin
                    mag = 5'd0;
                end
                else if (playback_speed == 3'd1)
                begin
                    mag = 5'd1;
                end
                else
                begin
                    // hold the frame until the repeat count is reached
                    if (rc_inc >= odtp_pkg::step_repeats(playback_speed))
                    begin
                        mag = 5'd1;
                    end
                    else
                    begin
                        mag     = 5'd0;
                        rc_next = rc_inc;
                    end
                end
            end
            odtp_pkg::PB_FAST_FWD:
            begin
                apply_dir = 1'b1;
                mag       = odtp_pkg::ff_step(playback_speed);
            end
            default:
            begin
                mag = 5'd1;
            end
        endcase
    end

    always_comb
    begin
        trick.repeat_next = rc_next;
        if (apply_dir && reverse)
        begin
            trick.step = 6'd0 - {1'b0, mag};
        end
        else
        begin
            trick.step = {1'b0, mag};
        end
    end

endmodule

FILE: hw/rtl/optical_disc_transport_trick_play_top.sv
// Disc transport controller with laser-model trick play. Every request (seek, sector tick,
// play, pause, stop) yields one result in the output or skid register; a new request can
// be accepted every cycle while the skid entry is empty, so the two-entry output buffer
// keeps requests flowing while a result waits downstream. Seek latency is counted down on
// sector ticks; the step per tick comes from the playback mode, speed and reverse
// registers when the laser model is on and the read is open ended. Configuration registers
// sit at APB byte address 4*index; the user must write them only while idle (unenforced).
module optical_disc_transport_trick_play_top (
    input  logic                          clk,
    input  logic                          rst_n,
    odtp_in_if.sink                       req,
    odtp_out_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [odtp_pkg::APB_AW-1:0]   paddr,
    input  logic [odtp_pkg::APB_DW-1:0]   pwdata,
    output logic [odtp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SW = odtp_pkg::SECTOR_W;
    localparam int RW = 1 + SW + odtp_pkg::MODE_W + 1 + 1;

    // configuration
    logic [1:0]    pb_mode_reg;
    logic [2:0]    pb_speed_reg;
    logic          reverse_reg;
    logic          stop_en_reg;
    logic [SW-1:0] stop_sector_reg;
    logic [SW-1:0] end_sector_reg;
    logic [SW-1:0] disc_end_reg;
    logic          laser_reg;

    // transport state
    odtp_pkg::mode_t                mode_reg, mode_next;
    odtp_pkg::mode_t                after_seek_reg, after_seek_next;
    logic [odtp_pkg::LATENCY_W-1:0] latency_reg, latency_next;
    logic [SW-1:0]                  cur_sector_reg, cur_sector_next;
    logic [SW-1:0]                  start_sector_reg, start_sector_next;
    logic [odtp_pkg::REPEAT_W-1:0]  repeat_reg, repeat_next;
    logic                           open_ended_reg, open_ended_next;

    // result
    logic          res_valid;
    logic [SW-1:0] res_sector;
    logic          res_hit;
    logic          res_ended;
    logic [RW-1:0] res_word;

    logic          out_valid_reg, skid_valid_reg;
    logic [RW-1:0] out_data_reg, skid_data_reg;

    logic accept;
    logic pop;
    logic cfg_wr;

    odtp_pkg::trick_t trick;

    logic [odtp_pkg::LATENCY_W-1:0] lat_dec;
    logic                           seek_done;
    odtp_pkg::mode_t                tick_mode;
    logic [SW-1:0]                  tick_sector;
    logic [SW-1:0]                  end_eff;
    logic                           trick_en;
    logic [odtp_pkg::STEP_W-1:0]    step;
    logic [SW+1:0]                  next_pos;
    logic                           in_disc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_mode_reg     <= '0;
            pb_speed_reg    <= '0;
            reverse_reg     <= 1'b0;
            stop_en_reg     <= 1'b0;
            stop_sector_reg <= '0;
            end_sector_reg  <= '0;
            disc_end_reg    <= '0;
            laser_reg       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                odtp_pkg::REG_PLAYBACK_MODE:   pb_mode_reg     <= pwdata[1:0];
                odtp_pkg::REG_PLAYBACK_SPEED:  pb_speed_reg    <= pwdata[2:0];
                odtp_pkg::REG_REVERSE:         reverse_reg     <= pwdata[0];
                odtp_pkg::REG_STOP_ENABLE:     stop_en_reg     <= pwdata[0];
                odtp_pkg::REG_STOP_SECTOR:     stop_sector_reg <= pwdata[SW-1:0];
                odtp_pkg::REG_END_SECTOR:      end_sector_reg  <= pwdata[SW-1:0];
                odtp_pkg::REG_DISC_END_SECTOR: disc_end_reg    <= pwdata[SW-1:0];
                odtp_pkg::REG_LASER_MODEL:     laser_reg       <= pwdata[0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            odtp_pkg::REG_PLAYBACK_MODE:   prdata = {30'd0, pb_mode_reg};
            odtp_pkg::REG_PLAYBACK_SPEED:  prdata = {29'd0, pb_speed_reg};
            odtp_pkg::REG_REVERSE:         prdata = {31'd0, reverse_reg};
            odtp_pkg::REG_STOP_ENABLE:     prdata = {31'd0, stop_en_reg};
            odtp_pkg::REG_STOP_SECTOR:     prdata = {8'd0, stop_sector_reg};
            odtp_pkg::REG_END_SECTOR:      prdata = {8'd0, end_sector_reg};
            odtp_pkg::REG_DISC_END_SECTOR: prdata = {8'd0, disc_end_reg};
            odtp_pkg::REG_LASER_MODEL:     prdata = {31'd0, laser_reg};
            default:                       prdata = '0;
        endcase
    end

    odtp_trick u_trick (
        .playback_mode  (pb_mode_reg),
        .playback_speed (pb_speed_reg),
        .reverse        (reverse_reg),
        .repeat_count   (repeat_reg),
        .trick          (trick)
    );

    // seek countdown and the sector the tick works on
    assign lat_dec   = latency_reg - 16'd1;
    assign seek_done = (latency_reg == '0) || (lat_dec == '0);
    always_comb
    begin
        tick_mode   = mode_reg;
        tick_sector = cur_sector_reg;
        if (mode_reg == odtp_pkg::MODE_SEEKING && seek_done)
        begin
            tick_mode   = after_seek_reg;
            tick_sector = start_sector_reg;
        end
    end

    assign end_eff  = open_ended_reg ? odtp_pkg::OPEN_END : end_sector_reg;
    assign trick_en = laser_reg && (end_eff == odtp_pkg::OPEN_END);
    assign step     = trick_en ? trick.step : 6'd1;
    assign next_pos = {2'b00, tick_sector} + {{(SW-4){step[odtp_pkg::STEP_W-1]}}, step};
    // top bit set means the step went below sector zero
    assign in_disc  = !next_pos[SW+1] && (next_pos[SW:0] < {1'b0, disc_end_reg});

    always_comb
    begin
        mode_next         = mode_reg;
        after_seek_next   = after_seek_reg;
        latency_next      = latency_reg;
        cur_sector_next   = cur_sector_reg;
        start_sector_next = start_sector_reg;
        repeat_next       = repeat_reg;
        open_ended_next   = open_ended_reg;
        res_valid         = 1'b0;
        res_sector        = '0;
        res_hit           = 1'b0;
        res_ended         = 1'b0;
        case (odtp_pkg::req_t'(req.req_type))
            odtp_pkg::REQ_SEEK_PLAY, odtp_pkg::REQ_SEEK_PAUSE, odtp_pkg::REQ_SEEK_READ:
            begin
                mode_next         = odtp_pkg::MODE_SEEKING;
                start_sector_next = req.target_sector;
                latency_next      = req.seek_latency;
                open_ended_next   = (req.req_type != odtp_pkg::REQ_SEEK_READ);
                case (odtp_pkg::req_t'(req.req_type))
                    odtp_pkg::REQ_SEEK_PLAY:  after_seek_next = odtp_pkg::MODE_PLAYING;
                    odtp_pkg::REQ_SEEK_PAUSE: after_seek_next = odtp_pkg::MODE_PAUSED;
                    default:                  after_seek_next = odtp_pkg::MODE_READING;
                endcase
            end
            odtp_pkg::REQ_TICK:
            begin
                if (mode_reg == odtp_pkg::MODE_SEEKING)
                begin
                    if (latency_reg != '0)
                    begin
                        latency_next = lat_dec;
                    end
                    if (seek_done)
                    begin
                        mode_next       = after_seek_reg;
                        cur_sector_next = start_sector_reg;
                    end
                end
                if ((mode_reg != odtp_pkg::MODE_SEEKING || seek_done) &&
                    (tick_mode == odtp_pkg::MODE_PLAYING ||
                     tick_mode == odtp_pkg::MODE_READING))
                begin
                    res_valid  = 1'b1;
                    res_sector = tick_sector;
                    if (trick_en)
                    begin
                        repeat_next = trick.repeat_next;
                    end
                    if (in_disc)
                    begin
                        cur_sector_next = next_pos[SW-1:0];
                        if (next_pos[SW-1:0] == end_eff)
                        begin
                            mode_next = odtp_pkg::MODE_INACTIVE;
                            res_ended = 1'b1;
                        end
                        res_hit = laser_reg && stop_en_reg &&
                                  (next_pos[SW-1:0] == stop_sector_reg);
                    end
                    else
                    begin
                        mode_next = odtp_pkg::MODE_INACTIVE;
                        res_ended = 1'b1;
                    end
                end
            end
            odtp_pkg::REQ_PLAY, odtp_pkg::REQ_PAUSE:
            begin
                if (mode_reg == odtp_pkg::MODE_SEEKING)
                begin
                    after_seek_next = (req.req_type == odtp_pkg::REQ_PLAY) ?
                                      odtp_pkg::MODE_PLAYING : odtp_pkg::MODE_PAUSED;
                end
                else
                begin
                    mode_next = (req.req_type == odtp_pkg::REQ_PLAY) ?
                                odtp_pkg::MODE_PLAYING : odtp_pkg::MODE_PAUSED;
                end
            end
            odtp_pkg::REQ_STOP:
            begin
                mode_next = odtp_pkg::MODE_STOPPED;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    assign res_word = {res_valid, res_sector, mode_next, res_hit, res_ended};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= odtp_pkg::MODE_INACTIVE;
            after_seek_reg   <= odtp_pkg::MODE_INACTIVE;
            latency_reg      <= '0;
            cur_sector_reg   <= '0;
            start_sector_reg <= '0;
            repeat_reg       <= '0;
            open_ended_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            after_seek_reg   <= after_seek_next;
            latency_reg      <= latency_next;
            cur_sector_reg   <= cur_sector_next;
            start_sector_reg <= start_sector_next;
            repeat_reg       <= repeat_next;
            open_ended_reg   <= open_ended_next;
        end
    end

    // output register plus skid entry
    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && !skid_valid_reg;
    assign pop       = out_valid_reg && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= res_word;
            end
            else
            begin
                skid_data_reg <= res_word;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.sector_valid   = out_data_reg[RW-1];
    assign rsp.read_sector    = out_data_reg[RW-2 -: SW];
    assign rsp.mode_now       = out_data_reg[odtp_pkg::MODE_W+1 -: odtp_pkg::MODE_W];
    assign rsp.stop_point_hit = out_data_reg[1];
    assign rsp.ended          = out_data_reg[0];

endmodule

FILE: dv/tb_optical_disc_transport_trick_play_top.sv
import odtp_pkg::*;

typedef struct {
    logic                fetched;
    logic [SECTOR_W-1:0] sector;
    logic [MODE_W-1:0]   mode;
    logic                hit;
    logic                ended;
} transport_status_t;

class transport_tracker;
    pb_mode_t             pb_mode;
    logic [2:0]           speed;
    logic                 rev;
    logic                 stop_en;
    logic [SECTOR_W-1:0]  stop_sec;
    logic [SECTOR_W-1:0]  end_sec;
    logic [SECTOR_W-1:0]  disc_end;
    logic                 laser;

    mode_t                mode;
    mode_t                after_seek;
    logic [LATENCY_W-1:0] lat_left;
    logic [SECTOR_W-1:0]  head;
    logic [SECTOR_W-1:0]  seek_dest;
    logic [REPEAT_W-1:0]  hold_cnt;
    logic                 open_ended;

    transport_status_t    expected_q[$];
    int unsigned          errors;

    function new();
        pb_mode    = PB_NORMAL;
        speed      = '0;
        rev        = 1'b0;
        stop_en    = 1'b0;
        stop_sec   = '0;
        end_sec    = '0;
        disc_end   = '0;
        laser      = 1'b0;
        mode       = MODE_INACTIVE;
        after_seek = MODE_INACTIVE;
        lat_left   = '0;
        head       = '0;
        seek_dest  = '0;
        hold_cnt   = '0;
        open_ended = 1'b0;
        errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_PLAYBACK_MODE:   pb_mode  = pb_mode_t'(val[1:0]);
            REG_PLAYBACK_SPEED:  speed    = val[2:0];
            REG_REVERSE:         rev      = val[0];
            REG_STOP_ENABLE:     stop_en  = val[0];
            REG_STOP_SECTOR:     stop_sec = val[SECTOR_W-1:0];
            REG_END_SECTOR:      end_sec  = val[SECTOR_W-1:0];
            REG_DISC_END_SECTOR: disc_end = val[SECTOR_W-1:0];
            default:             laser    = val[0];
        endcase
    endfunction

    // predict the status of one accepted request and queue it
    function void take_request(logic [REQ_W-1:0] kind, logic [SECTOR_W-1:0] sec,
                               logic [LATENCY_W-1:0] lat);
        transport_status_t   s;
        logic                go;
        logic [SECTOR_W-1:0] stop_at;
        int                  step;
        int                  hold;
        int                  nxt;
        s.fetched = 1'b0;
        s.sector  = '0;
        s.hit     = 1'b0;
        s.ended   = 1'b0;
        case (kind)
            REQ_SEEK_PLAY, REQ_SEEK_PAUSE, REQ_SEEK_READ:
            begin
                mode = MODE_SEEKING;
                if (kind == REQ_SEEK_PLAY)
                    after_seek = MODE_PLAYING;
                else if (kind == REQ_SEEK_PAUSE)
                    after_seek = MODE_PAUSED;
                else
                    after_seek = MODE_READING;
                seek_dest  = sec;
                lat_left   = lat;
                open_ended = (kind != REQ_SEEK_READ);
            end
            REQ_TICK:
            begin
                go = 1'b1;
                if (mode == MODE_SEEKING)
                begin
                    if (lat_left != 0)
                    begin
                        lat_left = lat_left - 1'b1;
                        if (lat_left != 0)
                            go = 1'b0;
                    end
                    if (go)
                    begin
                        mode = after_seek;
                        head = seek_dest;
                    end
                end
                if (go && (mode == MODE_PLAYING || mode == MODE_READING))
                begin
                    stop_at   = open_ended ? OPEN_END : end_sec;
                    s.fetched = 1'b1;
                    s.sector  = head;
                    step      = 1;
                    // trick play only on an open-ended transfer
                    if (laser && stop_at == OPEN_END)
                    begin
                        case (pb_mode)
                            PB_FRAME_STEP:
                            begin
                                if (speed == 3'd0)
                                begin
                                    step     = 0;
                                    hold_cnt = '0;
                                end
                                else if (speed == 3'd1)
                                begin
                                    step     = 1;
                                    hold_cnt = '0;
                                end
                                else
                                begin
                                    case (speed)
                                        3'd2:    hold = 2;
                                        3'd3:    hold = 4;
                                        3'd4:    hold = 8;
                                        3'd5:    hold = 16;
                                        3'd6:    hold = 30;
                                        default: hold = 90;
                                    endcase
                                    hold_cnt = hold_cnt + 1'b1;
                                    step = (int'(hold_cnt) >= hold) ? 1 : 0;
                                end
                                if (rev)
                                    step = -step;
                                if (speed >= 3'd2 && step != 0)
                                    hold_cnt = '0;
                            end
                            PB_FAST_FWD:
                            begin
                                case (speed)
                                    3'd1:    step = 2;
                                    3'd2:    step = 3;
                                    3'd3:    step = 8;
                                    3'd4:    step = 14;
                                    3'd5:    step = 20;
                                    default: step = 1;
                                endcase
                                if (rev)
                                    step = -step;
                                hold_cnt = '0;
                            end
                            default: hold_cnt = '0;
                        endcase
                    end
                    nxt = int'(head) + step;
                    if (nxt >= 0 && nxt < int'(disc_end))
                    begin
                        head = nxt[SECTOR_W-1:0];
                        if (head == stop_at)
                        begin
                            mode    = MODE_INACTIVE;
                            s.ended = 1'b1;
                        end
                        if (laser && stop_en && head == stop_sec)
                            s.hit = 1'b1;
                    end
                    else
                    begin
                        // off the disc: head stays, transport goes inactive
                        mode    = MODE_INACTIVE;
                        s.ended = 1'b1;
                    end
                end
            end
            REQ_PLAY, REQ_PAUSE:
            begin
                if (mode == MODE_SEEKING)
                    after_seek = (kind == REQ_PLAY) ? MODE_PLAYING : MODE_PAUSED;
                else
                    mode = (kind == REQ_PLAY) ? MODE_PLAYING : MODE_PAUSED;
            end
            REQ_STOP: mode = MODE_STOPPED;
            default: ;
        endcase
        s.mode = mode;
        expected_q.push_back(s);
    endfunction

    function void check_status(transport_status_t got);
        transport_status_t want;
        if (expected_q.size() == 0)
        begin
            $error("status transfer with no request outstanding");
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.fetched !== want.fetched)
        begin
            $error("sector_valid: expected %0d, got %0d", want.fetched, got.fetched);
            errors++;
        end
        if (got.sector !== want.sector)
        begin
            $error("read_sector: expected %0h, got %0h", want.sector, got.sector);
            errors++;
        end
        if (got.mode !== want.mode)
        begin
            $error("mode_now: expected %0d, got %0d", want.mode, got.mode);
            errors++;
        end
        if (got.hit !== want.hit)
        begin
            $error("stop_point_hit: expected %0d, got %0d", want.hit, got.hit);
            errors++;
        end
        if (got.ended !== want.ended)
        begin
            $error("ended: expected %0d, got %0d", want.ended, got.ended);
            errors++;
        end
    endfunction
endclass

module tb_optical_disc_transport_trick_play_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_IGNORED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int WINDOW      = 200;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    odtp_in_if  req_if();
    odtp_out_if rsp_if();

    transport_tracker tracker = new();

    optical_disc_transport_trick_play_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        tracker.set_reg(idx, val);
    endtask

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [SECTOR_W-1:0] sec,
                                input logic [LATENCY_W-1:0] lat);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid         = 1'b1;
        req_if.req_type      = kind;
        req_if.target_sector = sec;
        req_if.seek_latency  = lat;
        do @(posedge clk); while (!req_if.ready);
        tracker.take_request(kind, sec, lat);
    endtask

    // wait until every status has come back and the block is quiet
    task automatic drain();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] cfg[8]);
        for (int i = 0; i < 8; i++)
            write_reg(i[2:0], cfg[i]);
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : status_mon
        transport_status_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.fetched = rsp_if.sector_valid;
            got.sector  = rsp_if.read_sector;
            got.mode    = rsp_if.mode_now;
            got.hit     = rsp_if.stop_point_hit;
            got.ended   = rsp_if.ended;
            tracker.check_status(got);
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("optical_disc_transport_trick_play_top regression: fail");
        $finish;
    end

    initial
    begin
        logic [31:0]          cfg[8];
        logic [SECTOR_W-1:0]  base;
        logic [SECTOR_W-1:0]  sec;
        logic [LATENCY_W-1:0] lat;
        logic [REQ_W-1:0]     kind;
        int                   n;
        int                   ticks;
        int                   r;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_TICK;
        req_if.target_sector = '0;
        req_if.seek_latency  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // frame step at speed 0, small disc, bounded read ending at 0x12
        cfg[REG_PLAYBACK_MODE]   = 32'(PB_FRAME_STEP);
        cfg[REG_PLAYBACK_SPEED]  = 0;
        cfg[REG_REVERSE]         = 0;
        cfg[REG_STOP_ENABLE]     = 1;
        cfg[REG_STOP_SECTOR]     = 32'h10;
        cfg[REG_END_SECTOR]      = 32'h12;
        cfg[REG_DISC_END_SECTOR] = 32'h14;
        cfg[REG_LASER_MODEL]     = 1;
        set_regs(cfg);
        send_request(REQ_TICK, 24'hFFFFFF, 16'hFFFF);      // tick while inactive
        send_request(REQ_STOP, 24'h0, 16'h0);
        send_request(REQ_TICK, 24'h0, 16'h0);              // tick while stopped
        send_request(REQ_SEEK_PLAY, 24'h10, 16'd2);
        send_request(REQ_PAUSE, 24'h0, 16'h0);             // only retargets the post-seek mode
        send_request(REQ_PLAY, 24'h0, 16'h0);
        send_request(REQ_TICK, 24'h0, 16'h0);              // latency still counting
        send_request(REQ_TICK, 24'h0, 16'h0);              // seek lands, zero step, stop point
        send_request(REQ_PAUSE, 24'h0, 16'h0);
        send_request(REQ_TICK, 24'h0, 16'h0);              // paused, nothing fetched
        send_request(REQ_SEEK_READ, 24'h11, 16'd0);
        send_request(REQ_TICK, 24'h0, 16'h0);              // reaches end sector
        send_request(REQ_SEEK_PLAY, 24'h13, 16'd0);
        send_request(REQ_TICK, 24'h0, 16'h0);
        send_request(REQ_IGNORED, 24'hABCDEF, 16'h1234);
        drain();

        // fast forward backwards at speed 7, bounded read with an open end sector
        cfg[REG_PLAYBACK_MODE]   = 32'(PB_FAST_FWD);
        cfg[REG_PLAYBACK_SPEED]  = 7;
        cfg[REG_REVERSE]         = 1;
        cfg[REG_STOP_ENABLE]     = 0;
        cfg[REG_STOP_SECTOR]     = 0;
        cfg[REG_END_SECTOR]      = 32'hFFFFFF;
        cfg[REG_DISC_END_SECTOR] = 32'hFFFFFF;
        cfg[REG_LASER_MODEL]     = 1;
        set_regs(cfg);
        send_request(REQ_SEEK_READ, 24'h0, 16'd0);
        send_request(REQ_TICK, 24'h0, 16'h0);              // steps below sector zero
        send_request(REQ_SEEK_PAUSE, 24'hFFFFFE, 16'hFFFF);
        send_request(REQ_TICK, 24'h0, 16'h0);
        send_request(REQ_SEEK_PLAY, 24'h5, 16'd1);
        send_request(REQ_TICK, 24'h0, 16'h0);
        send_request(REQ_TICK, 24'h0, 16'h0);

        for (int p = 0; p < 12; p++)
        begin
            drain();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            if (p == 0)
            begin
                base = '0;
                for (int i = 0; i < 8; i++)
                    cfg[i] = 0;
            end
            else if (p == 1)
            begin
                base                     = 24'hFFFF00;
                cfg[REG_PLAYBACK_MODE]   = 32'(PB_FAST_FWD);
                cfg[REG_PLAYBACK_SPEED]  = 7;
                cfg[REG_REVERSE]         = 1;
                cfg[REG_STOP_ENABLE]     = 1;
                cfg[REG_STOP_SECTOR]     = 32'hFFFFFF;
                cfg[REG_END_SECTOR]      = 32'hFFFFFF;
                cfg[REG_DISC_END_SECTOR] = 32'hFFFFFF;
                cfg[REG_LASER_MODEL]     = 1;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       base = '0;
                    1:       base = 24'hFFFF00;
                    default: base = SECTOR_W'($urandom_range(0, 24'hFFFE00));
                endcase
                cfg[REG_PLAYBACK_MODE]  = $urandom_range(0, 3);
                cfg[REG_PLAYBACK_SPEED] = $urandom_range(0, 7);
                cfg[REG_REVERSE]        = $urandom_range(0, 1);
                cfg[REG_STOP_ENABLE]    = 32'($urandom_range(0, 3) != 0);
                cfg[REG_STOP_SECTOR]    = 32'(base + $urandom_range(0, WINDOW));
                cfg[REG_END_SECTOR]     = ($urandom_range(0, 3) == 0) ? 32'hFFFFFF
                                          : 32'(base + $urandom_range(0, WINDOW));
                cfg[REG_DISC_END_SECTOR] = ($urandom_range(0, 3) == 0) ? 32'hFFFFFF
                                          : 32'(base + $urandom_range(20, WINDOW));
                cfg[REG_LASER_MODEL]    = 32'($urandom_range(0, 4) != 0);
            end
            set_regs(cfg);

            n = 0;
            while (n < 52)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    kind = REQ_SEEK_PLAY;
                else if (r < 55)
                    kind = REQ_SEEK_PAUSE;
                else
                    kind = REQ_SEEK_READ;
                if ($urandom_range(0, 9) == 0)
                    sec = SECTOR_W'($urandom_range(0, 24'hFFFFFF));
                else
                    sec = SECTOR_W'(base + $urandom_range(0, WINDOW));
                r = $urandom_range(0, 19);
                if (r < 14)
                    lat = LATENCY_W'($urandom_range(0, 3));
                else if (r < 17)
                    lat = LATENCY_W'($urandom_range(4, 20));
                else
                    lat = LATENCY_W'($urandom_range(0, 16'hFFFF));
                send_request(kind, sec, lat);
                n++;
                ticks = $urandom_range(1, 25);
                for (int t = 0; t < ticks; t++)
                begin
                    r = $urandom_range(0, 99);
                    sec = SECTOR_W'($urandom_range(0, 24'hFFFFFF));
                    lat = LATENCY_W'($urandom_range(0, 16'hFFFF));
                    if (r < 4)
                        kind = REQ_PLAY;
                    else if (r < 7)
                        kind = REQ_PAUSE;
                    else if (r < 9)
                        kind = REQ_STOP;
                    else if (r < 11)
                        kind = REQ_IGNORED;
                    else if (r < 14)
                    begin
                        // broken sequence: a fresh seek in the middle of a transfer
                        kind = 3'($urandom_range(0, 2));
                        sec  = SECTOR_W'(base + $urandom_range(0, WINDOW));
                        lat  = LATENCY_W'($urandom_range(0, 3));
                    end
                    else
                        kind = REQ_TICK;
                    send_request(kind, sec, lat);
                    if (kind != REQ_IGNORED)
                        n++;
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("optical_disc_transport_trick_play_top regression: pass");
        else
            $display("optical_disc_transport_trick_play_top regression: fail");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/odtp_pkg.sv
hw/rtl/odtp_if.sv
hw/rtl/odtp_trick.sv
hw/rtl/optical_disc_transport_trick_play_top.sv
dv/tb_optical_disc_transport_trick_play_top.sv
